// File: src/amfp_pkg.sv
// Shared types, character codes and the power-of-ten table for the
// mixed-fraction parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amfp_pkg;

  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  localparam logic [30:0] RUN_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'd0,
    PH_SIGN  = 4'd1,
    PH_INT   = 4'd2,
    PH_FRAC  = 4'd3,
    PH_TAIL  = 4'd4,
    PH_GAP   = 4'd5,
    PH_NUM   = 4'd6,
    PH_SLASH = 4'd7,
    PH_DEN   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_START,
    SQ_DIV,
    SQ_SUM,
    SQ_OUT
  } seq_t;

  typedef struct packed {
    phase_t      phase;
    logic        neg;
    logic [30:0] int_part;
    logic [30:0] num;
    logic [30:0] den;
    logic        seen;
    logic [3:0]  cnt;
    logic        err;
  } scan_t;

  function automatic logic [30:0] pow10(input logic [3:0] k);
    logic [30:0] p;
    case (k)
      4'd0:    p = 31'd1;
      4'd1:    p = 31'd10;
      4'd2:    p = 31'd100;
      4'd3:    p = 31'd1000;
      4'd4:    p = 31'd10000;
      4'd5:    p = 31'd100000;
      4'd6:    p = 31'd1000000;
      4'd7:    p = 31'd10000000;
      4'd8:    p = 31'd100000000;
      4'd9:    p = 31'd1000000000;
      default: p = 31'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: src/ascii_mixed_fraction_parser.sv
// Top level of the ASCII mixed-fraction parser: stream ports, sequencer,
// result assembly. Depends on amfp_pkg, amfp_scan, amfp_div.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] char_code, s_tlast last_char
//  m_*       out  m_tvalid/m_tready  m_tdata[63:0] value, m_tuser status
//
// Characters before the last one are taken back to back while the sequencer is idle.
// The last character holds the input while the sequencer runs start, divide, sum and
// output, with one divider step per quotient bit (31 + FRAC_BITS).
// rst is synchronous; no clearing pass, ready in the first cycle after reset.
// A pending result waits in the output register while the next text streams in;
// the next last character stalls at the output stage until that word is taken.
`timescale 1ns / 1ps
`default_nettype none

module ascii_mixed_fraction_parser #(
  parameter int FRAC_BITS       = amfp_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = amfp_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] char_code
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // [63:0] value
  output logic        m_tuser    // [0] status
);
  import amfp_pkg::*;

  localparam int DW      = 31 + FRAC_BITS;
  localparam int MW      = 32 + FRAC_BITS;
  localparam int OVF_BIT = 31 + FRAC_BITS;

  seq_t seq, seq_next;

  scan_t          st;
  logic           take;
  logic           scan_clear;
  logic           div_start;
  logic           div_busy;
  logic [DW-1:0]  quot;
  logic [30:0]    divisor;
  logic           bad_now;
  logic           out_load;

  logic           neg;
  logic           bad;
  logic [30:0]    int_part;
  logic [MW-1:0]  mag;
  logic [MW-1:0]  limit;
  logic           ovf;
  logic [63:0]    mag64;

  assign take = s_tvalid && s_tready;

  amfp_scan #(
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .clear     (scan_clear),
    .char_code (s_tdata),
    .st        (st)
  );

  // integer-only text keeps num = 0, den = 1, so the divider always runs
  assign divisor = (st.phase inside {PH_FRAC, PH_TAIL}) ? pow10(st.cnt) : st.den;

  assign bad_now = st.err || !st.seen ||
                   !(st.phase inside {PH_INT, PH_FRAC, PH_TAIL, PH_DEN}) ||
                   (st.phase == PH_DEN && st.den == '0);

  amfp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (st.num),
    .den   (divisor),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_IDLE:  if (take && s_tlast) seq_next = SQ_START;
      SQ_START: seq_next = SQ_DIV;
      SQ_DIV:   if (!div_busy) seq_next = SQ_SUM;
      SQ_SUM:   seq_next = SQ_OUT;
      SQ_OUT:   if (!m_tvalid || m_tready) seq_next = SQ_IDLE;
      default:  seq_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    div_start  = 1'b0;
    scan_clear = 1'b0;
    out_load   = 1'b0;
    case (seq)
      SQ_IDLE:  s_tready = !rst;
      SQ_START: begin
        div_start  = 1'b1;
        scan_clear = 1'b1;
      end
      SQ_OUT:   out_load = !m_tvalid || m_tready;
      default:  s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) seq <= SQ_IDLE;
    else     seq <= seq_next;
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg      <= st.neg;
      bad      <= bad_now;
      int_part <= st.int_part;
    end
    if (seq == SQ_SUM) begin
      mag <= {1'b0, int_part, {FRAC_BITS{1'b0}}} + {1'b0, quot};
    end
  end

  assign limit = MW'(1) << OVF_BIT;
  assign ovf   = neg ? (mag > limit) : (mag >= limit);
  assign mag64 = 64'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (bad || ovf) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= neg ? (64'd0 - mag64) : mag64;
        m_tuser <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 64'd0)
    else $error("error word carries a nonzero value");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> ((&m_tdata[63:OVF_BIT]) || !(|m_tdata[63:OVF_BIT])))
    else $error("ok word outside the Q31 range");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the last character");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy && seq == SQ_DIV)
    else $error("divider not running after start");
`endif

endmodule

`default_nettype wire

// File: src/amfp_scan.sv
// Character scanner: per-character parse state, digit runs with overflow check.
// Depends on amfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amfp_scan #(
  parameter int MAX_FRAC_DIGITS = amfp_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                take,
  input  wire                clear,
  input  wire [7:0]          char_code,
  output amfp_pkg::scan_t    st
);
  import amfp_pkg::*;

  scan_t       st_next;
  logic        is_dig;
  logic [3:0]  d;
  logic [34:0] int_run;
  logic [34:0] num_run;
  logic [34:0] den_run;

  function automatic logic [34:0] mul10_add(input logic [30:0] run, input logic [3:0] dg);
    logic [34:0] r;
    r = {4'b0, run};
    return (r << 3) + (r << 1) + {31'b0, dg};
  endfunction

  assign is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign d       = char_code[3:0];
  assign int_run = mul10_add(st.int_part, d);
  assign num_run = mul10_add(st.num, d);
  assign den_run = mul10_add(st.den, d);

  always_comb begin
    st_next = st;
    if (take && !st.err) begin
      case (st.phase)
        PH_LEAD: begin
          if (char_code == CH_SPACE) begin
            st_next.phase = PH_LEAD;
          end else if (char_code == CH_PLUS) begin
            st_next.phase = PH_SIGN;
          end else if (char_code == CH_MINUS) begin
            st_next.neg   = 1'b1;
            st_next.phase = PH_SIGN;
          end else if (is_dig) begin
            st_next.int_part = {27'b0, d};
            st_next.seen     = 1'b1;
            st_next.phase    = PH_INT;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_SIGN: begin
          if (is_dig) begin
            st_next.int_part = {27'b0, d};
            st_next.seen     = 1'b1;
            st_next.phase    = PH_INT;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_INT: begin
          if (is_dig) begin
            if (int_run > {4'b0, RUN_MAX}) st_next.err = 1'b1;
            else st_next.int_part = int_run[30:0];
          end else if (char_code == CH_POINT) begin
            st_next.phase = PH_FRAC;
          end else if (char_code == CH_SPACE) begin
            st_next.phase = PH_GAP;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_FRAC: begin
          if (!is_dig) begin
            st_next.phase = PH_TAIL;
          end else if (st.cnt < 4'(MAX_FRAC_DIGITS)) begin
            // at most MAX_FRAC_DIGITS digits; at the default of nine this never exceeds 31 bits
            st_next.num = num_run[30:0];
            st_next.cnt = st.cnt + 4'd1;
          end
        end
        PH_TAIL: begin
          st_next.phase = PH_TAIL;
        end
        PH_GAP: begin
          if (char_code == CH_SPACE) begin
            st_next.phase = PH_GAP;
          end else if (is_dig) begin
            st_next.num   = {27'b0, d};
            st_next.phase = PH_NUM;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_NUM: begin
          if (is_dig) begin
            if (num_run > {4'b0, RUN_MAX}) st_next.err = 1'b1;
            else st_next.num = num_run[30:0];
          end else if (char_code == CH_SLASH) begin
            st_next.phase = PH_SLASH;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_SLASH: begin
          if (is_dig) begin
            st_next.den   = {27'b0, d};
            st_next.phase = PH_DEN;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_DEN: begin
          if (is_dig) begin
            if (den_run > {4'b0, RUN_MAX}) st_next.err = 1'b1;
            else st_next.den = den_run[30:0];
          end else begin
            st_next.err = 1'b1;
          end
        end
        default: begin
          st_next.err = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      st.phase    <= PH_LEAD;
      st.neg      <= 1'b0;
      st.int_part <= '0;
      st.num      <= '0;
      st.den      <= 31'd1;
      st.seen     <= 1'b0;
      st.cnt      <= '0;
      st.err      <= 1'b0;
    end else begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// File: src/amfp_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// Depends on amfp_pkg only through the parameter default.
`timescale 1ns / 1ps
`default_nettype none

module amfp_div #(
  parameter int FRAC_BITS = amfp_pkg::FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire [30:0]            num,
  input  wire [30:0]            den,
  output logic                  busy,
  output logic [31+FRAC_BITS-1:0] quot
);
  import amfp_pkg::*;

  localparam int DW = 31 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [30:0]   rem;
  logic [30:0]   dvr;
  logic [32:0]   diff;
  logic          ge;

  // quot doubles as the dividend shifter: MSB goes out, quotient bit comes in
  assign diff = {1'b0, rem, quot[DW-1]} - {2'b0, dvr};
  assign ge   = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= {num, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      dvr  <= den;
    end else if (busy) begin
      quot <= {quot[DW-2:0], ge};
      rem  <= ge ? diff[30:0] : {rem[29:0], quot[DW-1]};
    end
  end

endmodule

`default_nettype wire
